// ===== design/vdi_pkg.sv =====
// vdi_pkg: shared constants and types for the vertex dedup indexer.
// No dependencies; imported by vdi_scan_ctrl and vertex_dedup_indexer_core.
package vdi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ATTR_W      = 32;
    localparam int KEY_W       = 8 * ATTR_W;
    localparam int OUT_IDX_W   = 10;

    typedef logic [ATTR_W-1:0]    attr_t;
    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [OUT_IDX_W-1:0] out_idx_t;

    // key store access from the sequencer
    typedef struct packed {
        logic wr_en;
        idx_t wr_addr;
        idx_t rd_addr;
    } ram_req_t;

    // one finished result
    typedef struct packed {
        logic     valid;
        out_idx_t index;
        logic     is_new;
        logic     full;
    } res_t;

endpackage

// ===== design/vdi_key_ram.sv =====
// vdi_key_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies; holds the vertex keys for vertex_dedup_indexer_core.
module vdi_key_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/vdi_scan_ctrl.sv =====
// vdi_scan_ctrl: lookup sequencer; walks the key store one entry a cycle
// through a single 256-bit equality compare. Depends on vdi_pkg.
module vdi_scan_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              start_of_mesh,
    input  vdi_pkg::key_t     key_in,
    input  vdi_pkg::key_t     ram_rdata,
    output vdi_pkg::ram_req_t ram_req,
    output vdi_pkg::key_t     ram_wdata,
    output logic              busy,
    output vdi_pkg::res_t     res
);
    import vdi_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;

    logic [1:0] state_reg, state_next;
    key_t       key_reg, key_next;
    cnt_t       count_reg, count_next;
    cnt_t       scan_reg, scan_next;
    idx_t       cmp_reg, cmp_next;
    logic       pend_reg, pend_next;
    res_t       res_reg, res_next;
    logic       hit;

    // shared compare: registered RAM word against the held key
    assign hit = pend_reg && (ram_rdata == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        cmp_next        = cmp_reg;
        pend_next       = 1'b0;
        res_next        = '0;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = count_reg[IDX_W-1:0];
        ram_req.rd_addr = scan_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key_in;
                    count_next = start_of_mesh ? '0 : count_reg;
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.valid = 1'b1;
                    res_next.index = OUT_IDX_W'(cmp_reg);
                    state_next     = ST_IDLE;
                end
                else if (scan_reg == count_reg)
                begin
                    // every stored entry compared, no match
                    res_next.valid = 1'b1;
                    if (count_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        res_next.full = 1'b1;
                    end
                    else
                    begin
                        ram_req.wr_en   = 1'b1;
                        res_next.index  = OUT_IDX_W'(count_reg[IDX_W-1:0]);
                        res_next.is_new = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    pend_next = 1'b1;
                    cmp_next  = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        scan_reg <= scan_next;
        cmp_reg  <= cmp_next;
    end

    assign ram_wdata = key_reg;
    assign busy      = (state_reg != ST_IDLE);
    assign res       = res_reg;

    a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid |-> !(res_reg.is_new && res_reg.full))
        else $error("new and full flagged together");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid && res_reg.full |-> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("full reported with free entries");

    a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid |-> $past(busy) && !busy)
        else $error("result without a lookup in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count past table depth");

endmodule

// ===== design/vertex_dedup_indexer_core.sv =====
// vertex_dedup_indexer_core: top level of the exact-match vertex dedup indexer.
// Depends on vdi_pkg, vdi_key_ram and vdi_scan_ctrl.
//
// channel   direction  handshake                       payload
// --------  ---------  ------------------------------  --------------------------------
// command   in         start & !busy                   start_of_mesh, position_x/y/z,
//                                                      tex_u, tex_v, normal_x/y/z
// result    out        done (one-cycle strobe)         vertex_index, is_new, table_full
//
// Scan: a lookup compares one stored entry per clock through a single key
// compare on the registered key store read port. A lookup stops at the first
// matching entry; a miss first compares every entry the table holds. busy
// falls as done rises, so the next command can transfer at the edge that
// ends the done cycle.
// Reset: rst_n asynchronously empties the table (entry count to zero); the key
// store itself is not cleared and needs no clearing pass.
// Stalls: the receiver cannot stall; done is high for exactly one cycle.
module vertex_dedup_indexer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                start_of_mesh,
    input  vdi_pkg::attr_t      position_x,
    input  vdi_pkg::attr_t      position_y,
    input  vdi_pkg::attr_t      position_z,
    input  vdi_pkg::attr_t      tex_u,
    input  vdi_pkg::attr_t      tex_v,
    input  vdi_pkg::attr_t      normal_x,
    input  vdi_pkg::attr_t      normal_y,
    input  vdi_pkg::attr_t      normal_z,
    output logic                done,
    output vdi_pkg::out_idx_t   vertex_index,
    output logic                is_new,
    output logic                table_full
);
    import vdi_pkg::*;

    key_t     key_in;
    key_t     ram_rdata;
    key_t     ram_wdata;
    ram_req_t ram_req;
    res_t     res;

    // full key, all eight attributes compared bit for bit
    assign key_in = {position_x, position_y, position_z, tex_u, tex_v,
                     normal_x, normal_y, normal_z};

    vdi_scan_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .start_of_mesh (start_of_mesh),
        .key_in        (key_in),
        .ram_rdata     (ram_rdata),
        .ram_req       (ram_req),
        .ram_wdata     (ram_wdata),
        .busy          (busy),
        .res           (res)
    );

    // key store; entries at or above the entry count are never compared
    vdi_key_ram #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (KEY_W),
        .ADDR_W (IDX_W)
    ) u_keys (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_wdata),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata)
    );

    assign done         = res.valid;
    assign vertex_index = res.index;
    assign is_new       = res.is_new;
    assign table_full   = res.full;

endmodule
